// ===== rtl/core/bmf_pkg.sv =====
package bmf_pkg;

  localparam int MAX_SIZE   = 256;
  localparam int STORE_ROWS = 8;
  localparam int WIN_RADIUS = 3;
  localparam int WIN_TAPS   = 2 * WIN_RADIUS + 1;
  localparam int POS_W      = $clog2(MAX_SIZE) + 1;
  localparam int COL_W      = $clog2(MAX_SIZE);
  localparam int SLOT_W     = $clog2(STORE_ROWS);
  localparam int ADDR_W     = SLOT_W + COL_W;
  localparam int MEM_DEPTH  = STORE_ROWS * MAX_SIZE;
  localparam int SUM_W      = 14;
  localparam int TAP_W      = $clog2(WIN_TAPS);
  localparam int RECIP_SHIFT = 20;
  localparam int RECIP_W    = 15;
  localparam logic [RECIP_W-1:0] RECIP_49 = RECIP_W'(((1 << RECIP_SHIFT) / 49) + 1);
  localparam int PROD_W     = SUM_W + RECIP_W;
  localparam int MIN_SIZE   = 4;

  localparam logic [POS_W-1:0] SIZE_RESET = POS_W'(MAX_SIZE);

  // one output pixel to compute
  typedef struct packed {
    logic [POS_W-1:0] row;
    logic [POS_W-1:0] col;
    logic [POS_W-1:0] size;
    logic             last;
  } bmf_job_t;

  // line store write request
  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    logic [7:0]        data;
  } bmf_wr_t;

  // reflect-101 mirroring of a coordinate
  function automatic logic [COL_W-1:0] bmf_mirror(input logic [POS_W+1:0] x,
                                                  input logic [POS_W-1:0] n);
    logic signed [POS_W+1:0] v;
    logic signed [POS_W+1:0] top;
    v   = $signed(x);
    top = $signed({2'b00, n}) - (POS_W+2)'(1);
    if (v < 0) v = -v;
    if (v > top) v = (top <<< 1) - v;
    return v[COL_W-1:0];
  endfunction

endpackage

// ===== rtl/core/box_mean_filter_7x7_reflect_core.sv =====
// 7x7 box mean filter with reflect-101 borders over a square grey frame.
// Input stream: s_axis carries one request per pixel in raster order
// (tuser = 0, tdata = pixel) or a drain tick (tuser = 1) sent after the
// frame to flush the output pixels still pending. Output stream: m_axis
// gives the filtered pixels in raster order, tlast on the frame's final one.
// cfg_we_i writes the frame size (4..256, clamped) and restarts the frame;
// write it only while the block is idle.
// The front takes a request, stores the pixel and queues an output job once
// that pixel's window is complete; the back reads the 49 window taps from the
// line store one per cycle, then accumulates, scales and presents the result,
// and takes no new job until that output pixel has been accepted; the single
// read port of the line store sets the sustained rate.
// A two-entry job queue lets the front keep taking pixels while the back
// works; when it fills, s_axis_tready drops. After a frame's last job the
// front holds off new requests until the back has finished.
// When m_axis_tready is low the result waits in the output register and the
// back stalls. Reset sets the frame size to 256 and clears all positions.
module box_mean_filter_7x7_reflect_core (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [bmf_pkg::POS_W-1:0] cfg_wdata_i,
  input  logic                      s_axis_tvalid,
  output logic                      s_axis_tready,
  input  logic [7:0]                s_axis_tdata,  // [7:0] pixel_in
  input  logic                      s_axis_tuser,  // [0] mode
  output logic                      m_axis_tvalid,
  input  logic                      m_axis_tready,
  output logic [7:0]                m_axis_tdata,  // [7:0] pixel_out
  output logic                      m_axis_tlast
);
  import bmf_pkg::*;

  bmf_job_t push_job, pop_job;
  bmf_wr_t  wr;
  logic     push, pop, full, empty, back_idle;

  bmf_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_mode_i   (s_axis_tuser),
    .in_pixel_i  (s_axis_tdata),
    .q_full_i    (full),
    .q_empty_i   (empty),
    .back_idle_i (back_idle),
    .q_push_o    (push),
    .q_job_o     (push_job),
    .wr_o        (wr)
  );

  bmf_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_job),
    .full_o      (full),
    .pop_i       (pop),
    .pop_data_o  (pop_job),
    .empty_o     (empty)
  );

  bmf_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .wr_i        (wr),
    .q_empty_i   (empty),
    .q_job_i     (pop_job),
    .q_pop_o     (pop),
    .idle_o      (back_idle),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_pixel_o (m_axis_tdata),
    .out_last_o  (m_axis_tlast)
  );
endmodule

// ===== rtl/core/bmf_queue.sv =====
module bmf_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  bmf_pkg::bmf_job_t push_data_i,
  output logic              full_o,
  input  logic              pop_i,
  output bmf_pkg::bmf_job_t pop_data_o,
  output logic              empty_o
);
  import bmf_pkg::*;

  bmf_job_t   slot_q [2];
  logic       wptr_q, rptr_q;
  logic [1:0] cnt_q;

  assign full_o     = (cnt_q == 2'd2);
  assign empty_o    = (cnt_q == 2'd0);
  assign pop_data_o = slot_q[rptr_q];

  // hold jobs between front and back
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      if (push_i) wptr_q <= ~wptr_q;
      if (pop_i) rptr_q <= ~rptr_q;
      cnt_q <= cnt_q + 2'(push_i) - 2'(pop_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) slot_q[wptr_q] <= push_data_i;
  end
endmodule

// ===== rtl/core/bmf_front.sv =====
module bmf_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [bmf_pkg::POS_W-1:0]     cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          in_mode_i,
  input  logic [7:0]                    in_pixel_i,
  input  logic                          q_full_i,
  input  logic                          q_empty_i,
  input  logic                          back_idle_i,
  output logic                          q_push_o,
  output bmf_pkg::bmf_job_t             q_job_o,
  output bmf_pkg::bmf_wr_t              wr_o
);
  import bmf_pkg::*;

  logic [POS_W-1:0] size_q, n;
  logic [POS_W-1:0] in_row_q, in_col_q, out_row_q, out_col_q;
  logic [POS_W-1:0] in_row_d, in_col_d;
  logic [POS_W:0]   need_r, need_c;
  logic             wait_q, accept, wr_en, ready, last;

  // clamp frame size to the legal range
  always_comb begin
    n = size_q;
    if (size_q < POS_W'(MIN_SIZE)) n = POS_W'(MIN_SIZE);
    if (size_q > POS_W'(MAX_SIZE)) n = POS_W'(MAX_SIZE);
  end

  assign in_ready_o = !q_full_i && !wait_q;
  assign accept     = in_valid_i && in_ready_o;
  assign wr_en      = accept && !in_mode_i && (in_row_q < n);

  // advance the input position
  always_comb begin
    in_row_d = in_row_q;
    in_col_d = in_col_q;
    if (wr_en) begin
      in_col_d = in_col_q + POS_W'(1);
      if (in_col_d >= n) begin
        in_col_d = '0;
        in_row_d = in_row_q + POS_W'(1);
      end
    end
  end

  // decide whether the next output window is complete
  always_comb begin
    need_r = {1'b0, out_row_q} + (POS_W+1)'(WIN_RADIUS);
    if (need_r > {1'b0, n} - (POS_W+1)'(1)) need_r = {1'b0, n} - (POS_W+1)'(1);
    need_c = {1'b0, out_col_q} + (POS_W+1)'(WIN_RADIUS);
    if (need_c > {1'b0, n} - (POS_W+1)'(1)) need_c = {1'b0, n} - (POS_W+1)'(1);
    ready = (out_row_q < n) &&
            (({1'b0, in_row_d} > need_r) ||
             (({1'b0, in_row_d} == need_r) && ({1'b0, in_col_d} > need_c)));
    last  = (out_row_q == n - POS_W'(1)) && (out_col_q == n - POS_W'(1));
  end

  assign q_push_o      = accept && ready;
  assign q_job_o.row   = out_row_q;
  assign q_job_o.col   = out_col_q;
  assign q_job_o.size  = n;
  assign q_job_o.last  = last;
  assign wr_o.en       = wr_en;
  assign wr_o.addr     = {in_row_q[SLOT_W-1:0], in_col_q[COL_W-1:0]};
  assign wr_o.data     = in_pixel_i;

  // hold counters; block new items after frame end until the back drains
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q    <= SIZE_RESET;
      in_row_q  <= '0;
      in_col_q  <= '0;
      out_row_q <= '0;
      out_col_q <= '0;
      wait_q    <= 1'b0;
    end else if (cfg_we_i) begin
      size_q    <= cfg_wdata_i;
      in_row_q  <= '0;
      in_col_q  <= '0;
      out_row_q <= '0;
      out_col_q <= '0;
      wait_q    <= 1'b0;
    end else begin
      if (wait_q && q_empty_i && back_idle_i) wait_q <= 1'b0;
      if (accept) begin
        in_row_q <= in_row_d;
        in_col_q <= in_col_d;
        if (ready) begin
          if (last) begin
            in_row_q  <= '0;
            in_col_q  <= '0;
            out_row_q <= '0;
            out_col_q <= '0;
            wait_q    <= 1'b1;
          end else if (out_col_q + POS_W'(1) >= n) begin
            out_col_q <= '0;
            out_row_q <= out_row_q + POS_W'(1);
          end else begin
            out_col_q <= out_col_q + POS_W'(1);
          end
        end
      end
    end
  end
endmodule

// ===== rtl/core/bmf_back.sv =====
module bmf_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  bmf_pkg::bmf_wr_t  wr_i,
  input  logic              q_empty_i,
  input  bmf_pkg::bmf_job_t q_job_i,
  output logic              q_pop_o,
  output logic              idle_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [7:0]        out_pixel_o,
  output logic              out_last_o
);
  import bmf_pkg::*;

  typedef enum logic [2:0] {S_IDLE, S_RUN, S_ACC, S_MUL, S_OUT} state_e;

  logic [7:0]        mem [MEM_DEPTH];
  state_e            state_q;
  bmf_job_t          job_q;
  logic [TAP_W-1:0]  dr_q, dc_q;
  logic [SUM_W-1:0]  acc_q;
  logic [PROD_W-1:0] prod_q;
  logic              rd_v_q;
  logic [7:0]        rd_data_q;
  logic [COL_W-1:0]  rr, cc;
  logic [ADDR_W-1:0] rd_addr;
  logic              tap_end;

  // mirrored window address
  always_comb begin
    rr = bmf_mirror((POS_W+2)'({2'b00, job_q.row}) + (POS_W+2)'(dr_q)
                    - (POS_W+2)'(WIN_RADIUS), job_q.size);
    cc = bmf_mirror((POS_W+2)'({2'b00, job_q.col}) + (POS_W+2)'(dc_q)
                    - (POS_W+2)'(WIN_RADIUS), job_q.size);
    rd_addr = {rr[SLOT_W-1:0], cc};
    tap_end = (dr_q == TAP_W'(WIN_TAPS - 1)) && (dc_q == TAP_W'(WIN_TAPS - 1));
  end

  // line store
  always_ff @(posedge clk_i) begin
    if (wr_i.en) mem[wr_i.addr] <= wr_i.data;
    rd_data_q <= mem[rd_addr];
  end

  assign q_pop_o     = (state_q == S_IDLE) && !q_empty_i;
  assign idle_o      = (state_q == S_IDLE);
  assign out_valid_o = (state_q == S_OUT);
  assign out_pixel_o = prod_q[RECIP_SHIFT +: 8];
  assign out_last_o  = job_q.last;

  // sweep 49 taps, accumulate, scale by 1/49, hold result
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      job_q   <= '0;
      rd_v_q  <= 1'b0;
      dr_q    <= '0;
      dc_q    <= '0;
      acc_q   <= '0;
      prod_q  <= '0;
    end else begin
      rd_v_q <= (state_q == S_RUN);
      if (rd_v_q) acc_q <= acc_q + SUM_W'(rd_data_q);
      case (state_q)
        S_IDLE: begin
          if (!q_empty_i) begin
            job_q   <= q_job_i;
            dr_q    <= '0;
            dc_q    <= '0;
            acc_q   <= '0;
            state_q <= S_RUN;
          end
        end
        S_RUN: begin
          if (tap_end) begin
            state_q <= S_ACC;
          end else if (dc_q == TAP_W'(WIN_TAPS - 1)) begin
            dc_q <= '0;
            dr_q <= dr_q + TAP_W'(1);
          end else begin
            dc_q <= dc_q + TAP_W'(1);
          end
        end
        S_ACC: state_q <= S_MUL;
        S_MUL: begin
          prod_q  <= PROD_W'(acc_q) * PROD_W'(RECIP_49);
          state_q <= S_OUT;
        end
        S_OUT: begin
          if (out_ready_i) state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end
endmodule

// ===== tb/tb_box_mean_filter_7x7_reflect_core.sv =====
module tb_box_mean_filter_7x7_reflect_core;
  import bmf_pkg::*;

  localparam bit MODE_PIXEL = 1'b0;
  localparam bit MODE_DRAIN = 1'b1;
  localparam int WIN_AREA   = 49;
  localparam int SETTLE_CYC = 120;
  localparam int STALL_LIMIT = 5000;
  localparam int RANDOM_ITEMS = 500;

  typedef struct packed {
    logic [7:0] pixel;
    logic       last;
  } filt_px_t;

  typedef struct packed {
    bit         mode;
    logic [7:0] pixel;
    bit         typed;
    filt_px_t   want;
  } stim_row_t;

  logic             clk_i;
  logic             rst_ni;
  logic             cfg_we_i;
  logic [POS_W-1:0] cfg_wdata_i;
  logic             s_axis_tvalid;
  logic             s_axis_tready;
  logic [7:0]       s_axis_tdata;
  logic             s_axis_tuser;
  logic             m_axis_tvalid;
  logic             m_axis_tready = 1'b0;
  logic [7:0]       m_axis_tdata;
  logic             m_axis_tlast;

  box_mean_filter_7x7_reflect_core u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast)
  );

  // mirror of the filter state
  logic [7:0] rows_mem [0:STORE_ROWS*MAX_SIZE-1];
  int         side_len;
  int         wr_row, wr_col, rd_row, rd_col;
  filt_px_t   pending_px [$];
  int         fail_cnt;
  int         idle_cyc = 0;
  int         burst_left;
  int         stall_mode = 0, stall_left = 0;

  always begin
    clk_i = 1'b1; #5;
    clk_i = 1'b0; #5;
  end

  function automatic int reflect101(input int x, input int n);
    if (x < 0) x = -x;
    if (x > n - 1) x = 2 * (n - 1) - x;
    return x;
  endfunction

  function automatic void restart_frame();
    wr_row = 0; wr_col = 0; rd_row = 0; rd_col = 0;
  endfunction

  function automatic bit frame_busy();
    return (wr_row | wr_col | rd_row | rd_col) != 0;
  endfunction

  // advance the filter by one request; report the output pixel if one is due
  function automatic bit filter_step(input bit mode, input logic [7:0] pix,
                                     output filt_px_t res);
    int need_r, need_c, sum, rr, cc;
    bit ok;
    res = '0;
    sum = 0;
    if (mode == MODE_PIXEL && wr_row < side_len) begin
      rows_mem[(wr_row % STORE_ROWS) * MAX_SIZE + wr_col] = pix;
      wr_col++;
      if (wr_col >= side_len) begin
        wr_col = 0;
        wr_row++;
      end
    end
    if (rd_row >= side_len || rd_col >= side_len) return 0;
    need_r = (rd_row + WIN_RADIUS > side_len - 1) ? side_len - 1 : rd_row + WIN_RADIUS;
    need_c = (rd_col + WIN_RADIUS > side_len - 1) ? side_len - 1 : rd_col + WIN_RADIUS;
    ok = wr_row > need_r || (wr_row == need_r && wr_col > need_c);
    if (!ok) return 0;
    for (int dr = -WIN_RADIUS; dr <= WIN_RADIUS; dr++) begin
      rr = reflect101(rd_row + dr, side_len);
      for (int dc = -WIN_RADIUS; dc <= WIN_RADIUS; dc++) begin
        cc = reflect101(rd_col + dc, side_len);
        sum += rows_mem[(rr % STORE_ROWS) * MAX_SIZE + cc];
      end
    end
    res.pixel = 8'(sum / WIN_AREA);
    res.last  = (rd_row == side_len - 1) && (rd_col == side_len - 1);
    if (res.last) begin
      restart_frame();
    end else begin
      rd_col++;
      if (rd_col >= side_len) begin
        rd_col = 0;
        rd_row++;
      end
    end
    return 1;
  endfunction

  // send one request in bursts with random gaps, then predict its output
  task automatic send_req(input bit mode, input logic [7:0] pix, input bit typed,
                          input filt_px_t want);
    filt_px_t res;
    bit got;
    @(negedge clk_i);
    if (burst_left == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk_i);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= mode;
    s_axis_tdata  <= pix;
    do @(posedge clk_i); while (!s_axis_tready);
    got = filter_step(mode, pix, res);
    if (typed) pending_px.push_back(want);
    else if (got) pending_px.push_back(res);
  endtask

  // wait for all outputs, then let the back end settle
  task automatic wait_idle();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (pending_px.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYC) @(posedge clk_i);
  endtask

  task automatic write_size(input logic [POS_W-1:0] val);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= val;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    side_len = (val < MIN_SIZE) ? MIN_SIZE : ((val > MAX_SIZE) ? MAX_SIZE : int'(val));
    restart_frame();
  endtask

  task automatic drain_frame();
    while (frame_busy()) send_req(MODE_DRAIN, 8'($urandom), 1'b0, '0);
  endtask

  // receiver stall pattern: always ready, random, or mostly stalled
  always @(negedge clk_i) begin
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 2);
      stall_left = $urandom_range(20, 300);
    end else begin
      stall_left--;
    end
    case (stall_mode)
      0: m_axis_tready <= 1'b1;
      1: m_axis_tready <= 1'($urandom);
      default: m_axis_tready <= ($urandom_range(0, 3) == 0);
    endcase
  end

  // check each output pixel against the oldest prediction
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_px.size() == 0) begin
        $error("unexpected output pixel: pixel_out=%0d frame_last=%0b",
               m_axis_tdata, m_axis_tlast);
        fail_cnt++;
      end else begin
        filt_px_t w;
        w = pending_px.pop_front();
        if (m_axis_tdata !== w.pixel) begin
          $error("pixel_out: expected %0d, got %0d", w.pixel, m_axis_tdata);
          fail_cnt++;
        end
        if (m_axis_tlast !== w.last) begin
          $error("frame_last: expected %0b, got %0b", w.last, m_axis_tlast);
          fail_cnt++;
        end
      end
    end
  end

  // watchdog on cycles without any request or output moving
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cyc = 0;
    end else begin
      idle_cyc++;
      if (idle_cyc >= STALL_LIMIT) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  initial begin
    stim_row_t dir_rows [20];
    int sent, phase, n_val, style;
    logic [7:0] pix;

    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_wdata_i = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = 1'b0;
    fail_cnt = 0;
    burst_left = 0;
    side_len = MAX_SIZE;
    restart_frame();
    for (int i = 0; i < STORE_ROWS * MAX_SIZE; i++) rows_mem[i] = '0;

    // a 4x4 frame of full-scale pixels: every output is 255
    for (int i = 0; i < 20; i++) begin
      dir_rows[i].mode  = (i < 16) ? MODE_PIXEL : MODE_DRAIN;
      dir_rows[i].pixel = (i < 16) ? 8'hFF : 8'h00;
      dir_rows[i].typed = (i >= 15);
      dir_rows[i].want  = '{pixel: 8'hFF, last: 1'b0};
    end

    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // size zero acts as the minimum
    write_size('0);
    foreach (dir_rows[i])
      send_req(dir_rows[i].mode, dir_rows[i].pixel, dir_rows[i].typed, dir_rows[i].want);
    drain_frame();

    sent = 0;
    phase = 0;
    while (sent < RANDOM_ITEMS) begin
      wait_idle();
      if (phase == 3) begin
        // oversize value clamps to the maximum; no window completes this early
        write_size('1);
        for (int i = 0; i < 40; i++)
          send_req(MODE_PIXEL, 8'($urandom), 1'b0, '0);
        phase++;
        continue;
      end
      // new size and restart on the first pass, after the partial oversize frame, and at random otherwise
      if (phase == 0 || phase == 4 || $urandom_range(0, 4) != 0) begin
        n_val = ($urandom_range(0, 9) < 2) ? $urandom_range(0, 3) : $urandom_range(4, 12);
        write_size(POS_W'(n_val));
      end
      style = $urandom_range(0, 5);
      for (int i = 0; i < side_len * side_len; i++) begin
        // stray drain ticks inside the frame
        if ($urandom_range(0, 11) == 0) send_req(MODE_DRAIN, 8'($urandom), 1'b0, '0);
        pix = (style == 0) ? 8'hFF : (style == 1) ? 8'h00 : 8'($urandom);
        send_req(MODE_PIXEL, pix, 1'b0, '0);
        sent++;
      end
      // surplus pixels after the frame only flush
      repeat ($urandom_range(0, 3)) send_req(MODE_PIXEL, 8'($urandom), 1'b0, '0);
      drain_frame();
      phase++;
    end

    wait_idle();
    if (pending_px.size() != 0) fail_cnt++;
    if (fail_cnt == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
